@@ src/lpe_pkg.sv @@
// Shared constants, coefficient tables and arithmetic helpers for the Legendre evaluator.
// Used by legendre_polynomial_eval_core and its checker; depends on nothing else.
package lpe_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_ORDER_DEF = 12;
	localparam int XW = 18;
	localparam int CW = 22;
	localparam int AW = 40;
	localparam int PW = AW + XW;
	localparam int ONE = 1 << FRAC_BITS;
	localparam int HALF = 1 << (FRAC_BITS - 1);

	localparam logic signed [XW-1:0] ONE_X = XW'(ONE);
	localparam logic signed [AW-1:0] ONE_A = AW'(ONE);

	localparam int COEF_TAB [0:15][0:6] = '{
		'{1, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0},
		'{3, -1, 0, 0, 0, 0, 0},
		'{5, -3, 0, 0, 0, 0, 0},
		'{35, -30, 3, 0, 0, 0, 0},
		'{63, -70, 15, 0, 0, 0, 0},
		'{231, -315, 105, -5, 0, 0, 0},
		'{429, -693, 315, -35, 0, 0, 0},
		'{6435, -12012, 6930, -1260, 35, 0, 0},
		'{12155, -25740, 18018, -4620, 315, 0, 0},
		'{46189, -109395, 90090, -30030, 3465, -63, 0},
		'{88179, -230945, 218790, -90090, 15015, -693, 0},
		'{676039, -1939938, 2078505, -1021020, 225225, -18018, 231},
		'{0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0, 0}
	};

	localparam int SHIFT_TAB [0:15] = '{0, 0, 1, 1, 3, 3, 4, 4, 7, 7, 8, 8, 10, 0, 0, 0};

	// Coefficient for Horner slot j of a chain with nstep steps. Lower orders are
	// padded with leading zeros so that every order runs through the same chain.
	function automatic logic signed [CW-1:0] lpe_coef(input logic [3:0] n, input int j,
			input int nstep, input int max_order);
		int cnt;
		int k;
		logic signed [CW-1:0] c;
		cnt = int'(n >> 1) + 1;
		k = j - (nstep + 1 - cnt);
		c = '0;
		if (int'(n) <= max_order && k >= 0) begin
			c = CW'(COEF_TAB[n][k[2:0]]);
		end
		return c;
	endfunction

	// Coefficient aligned to the accumulator's fixed point.
	function automatic logic signed [AW-1:0] lpe_coef_fx(input logic signed [CW-1:0] c);
		return {{(AW - CW - FRAC_BITS){c[CW-1]}}, c, {FRAC_BITS{1'b0}}};
	endfunction

	// Product scaled down by the fraction bits, rounded to nearest with ties away from zero.
	function automatic logic signed [AW-1:0] lpe_round(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + PW'(HALF) - PW'(p[PW-1]);
		return AW'(t >>> FRAC_BITS);
	endfunction

	// Final power-of-two scale with rounding, then saturation to plus or minus one.
	function automatic logic signed [XW-1:0] lpe_scale(input logic signed [AW-1:0] a,
			input logic [3:0] n);
		logic [3:0] s;
		logic signed [AW-1:0] t;
		logic signed [AW-1:0] r;
		s = 4'(SHIFT_TAB[n]);
		t = a;
		if (s != 4'd0) begin
			t = a + (AW'(1) << (s - 4'd1)) - AW'(a[AW-1]);
		end
		r = t >>> s;
		if (r > ONE_A) begin
			r = ONE_A;
		end else if (r < -ONE_A) begin
			r = -ONE_A;
		end
		return XW'(r);
	endfunction

endpackage

@@ src/legendre_polynomial_eval_core.sv @@
// Top level of the Legendre polynomial evaluator: a pipelined Horner chain in x squared.
// Depends on lpe_pkg for the coefficient tables and the rounding helpers.
//
// Usage: an input transfer carries an order (0 to 12) and an argument x in signed
// fixed point with 16 fraction bits; x beyond plus or minus one is clamped. Each input
// transfer yields exactly one output transfer with P_n(x), rounded and saturated to
// plus or minus one, and a bad_order flag that is set, with a zero value, when the
// order exceeds MAX_ORDER. Results leave in the order the items arrived.
// Along the pipeline, one stage clamps x and squares it and one stage per Horner
// step multiplies and adds a coefficient; one stage applies the extra factor x for
// odd orders, and one stage scales and saturates. One item per cycle unless stalled;
// every stage but the last holds its own multiplier. The whole pipeline advances
// together whenever the output register is empty or its result is being taken, so a
// stalled receiver holds every stage and in_ready falls; nothing is dropped or
// repeated. Reset clears all valid bits and takes effect at once; the block keeps no
// other state.
module legendre_polynomial_eval_core #(
	parameter int MAX_ORDER = lpe_pkg::MAX_ORDER_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [3:0]                     order,
	input  logic signed [lpe_pkg::XW-1:0]  arg_x,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [lpe_pkg::XW-1:0]  poly_value,
	output logic                           bad_order
);

	localparam int NSTEP = MAX_ORDER / 2;

	logic advance;

	logic                          valid_s [NSTEP+1];
	logic [3:0]                    order_s [NSTEP+1];
	logic                          bad_s [NSTEP+1];
	logic signed [lpe_pkg::XW-1:0] x_s [NSTEP+1];
	logic signed [lpe_pkg::XW-1:0] y_s [NSTEP+1];
	logic signed [lpe_pkg::AW-1:0] acc_s [NSTEP+1];

	logic                          odd_valid_s;
	logic [3:0]                    odd_order_s;
	logic                          odd_bad_s;
	logic signed [lpe_pkg::AW-1:0] odd_acc_s;

	logic                          res_valid_s;
	logic                          res_bad_s;
	logic signed [lpe_pkg::XW-1:0] res_value_s;

	logic signed [lpe_pkg::XW-1:0] x_clamp;
	logic signed [lpe_pkg::PW-1:0] sq_prod;
	logic signed [lpe_pkg::PW-1:0] odd_prod;
	logic signed [lpe_pkg::AW-1:0] odd_acc;

	assign advance = !res_valid_s || out_ready;
	assign in_ready = advance;

	always_comb begin
		x_clamp = arg_x;
		if (arg_x > lpe_pkg::ONE_X) begin
			x_clamp = lpe_pkg::ONE_X;
		end else if (arg_x < -lpe_pkg::ONE_X) begin
			x_clamp = -lpe_pkg::ONE_X;
		end
		sq_prod = x_clamp * x_clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (advance) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			order_s[0] <= order;
			bad_s[0] <= order > 4'(MAX_ORDER);
			x_s[0] <= x_clamp;
			y_s[0] <= lpe_pkg::XW'(lpe_pkg::lpe_round(sq_prod));
			acc_s[0] <= lpe_pkg::lpe_coef_fx(lpe_pkg::lpe_coef(order, 0, NSTEP, MAX_ORDER));
		end
	end

	for (genvar j = 1; j <= NSTEP; j++) begin : g_horner
		logic signed [lpe_pkg::PW-1:0] prod;
		logic signed [lpe_pkg::AW-1:0] acc_next;

		always_comb begin
			prod = acc_s[j-1] * y_s[j-1];
			acc_next = lpe_pkg::lpe_round(prod)
				+ lpe_pkg::lpe_coef_fx(lpe_pkg::lpe_coef(order_s[j-1], j, NSTEP, MAX_ORDER));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (advance) begin
				valid_s[j] <= valid_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				order_s[j] <= order_s[j-1];
				bad_s[j] <= bad_s[j-1];
				x_s[j] <= x_s[j-1];
				y_s[j] <= y_s[j-1];
				acc_s[j] <= acc_next;
			end
		end
	end

	always_comb begin
		odd_prod = acc_s[NSTEP] * x_s[NSTEP];
		odd_acc = acc_s[NSTEP];
		if (order_s[NSTEP][0]) begin
			odd_acc = lpe_pkg::lpe_round(odd_prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_valid_s <= 1'b0;
			res_valid_s <= 1'b0;
		end else if (advance) begin
			odd_valid_s <= valid_s[NSTEP];
			res_valid_s <= odd_valid_s;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			odd_order_s <= order_s[NSTEP];
			odd_bad_s <= bad_s[NSTEP];
			odd_acc_s <= odd_acc;
			res_bad_s <= odd_bad_s;
			res_value_s <= odd_bad_s ? '0 : lpe_pkg::lpe_scale(odd_acc_s, odd_order_s);
		end
	end

	assign out_valid = res_valid_s;
	assign poly_value = res_value_s;
	assign bad_order = res_bad_s;

endmodule

@@ src/lpe_checker.sv @@
// Port-level checker for legendre_polynomial_eval_core, attached with a bind statement.
// Depends on lpe_pkg for the fixed-point width and the value of one.
module lpe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [lpe_pkg::XW-1:0]  poly_value,
	input logic                           bad_order
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(poly_value) && $stable(bad_order))
		else $error("Output transfer changed while stalled.");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_order |-> poly_value == '0)
		else $error("Bad order result carries a nonzero value.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> poly_value <= lpe_pkg::ONE_X && poly_value >= -lpe_pkg::ONE_X)
		else $error("Result lies outside plus or minus one.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled while the output register is empty.");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("Input taken while the pipeline is stalled.");

endmodule

bind legendre_polynomial_eval_core lpe_checker u_lpe_checker (.*);

@@ dv/tb_legendre_polynomial_eval_core.sv @@
// Testbench for legendre_polynomial_eval_core: directed table, then random orders and arguments.
// Results are checked field by field against the table's own values where given, else
// against a Horner predictor in x squared held here. Depends on lpe_pkg and the core only.
module tb_legendre_polynomial_eval_core;
	localparam int XW = lpe_pkg::XW;
	localparam int FRAC_BITS = lpe_pkg::FRAC_BITS;

	localparam int TOP_ORDER = 12;
	localparam longint UNITY = longint'(1) << FRAC_BITS;
	localparam int RANDOM_ITEMS = 800;
	localparam int CALM_ITEMS = 150;

	localparam longint LEG_COEF [0:12][0:6] = '{
		'{1, 0, 0, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0},
		'{3, -1, 0, 0, 0, 0, 0},
		'{5, -3, 0, 0, 0, 0, 0},
		'{35, -30, 3, 0, 0, 0, 0},
		'{63, -70, 15, 0, 0, 0, 0},
		'{231, -315, 105, -5, 0, 0, 0},
		'{429, -693, 315, -35, 0, 0, 0},
		'{6435, -12012, 6930, -1260, 35, 0, 0},
		'{12155, -25740, 18018, -4620, 315, 0, 0},
		'{46189, -109395, 90090, -30030, 3465, -63, 0},
		'{88179, -230945, 218790, -90090, 15015, -693, 0},
		'{676039, -1939938, 2078505, -1021020, 225225, -18018, 231}
	};
	localparam int LEG_SHIFT [0:12] = '{0, 0, 1, 1, 3, 3, 4, 4, 7, 7, 8, 8, 10};

	typedef struct packed {
		logic signed [XW-1:0] value;
		logic bad;
	} legendre_out_t;

	typedef struct packed {
		logic [3:0] ord;
		logic signed [XW-1:0] x;
		logic typed;
		logic signed [XW-1:0] value;
		logic bad;
	} directed_row_t;

	localparam int NUM_ROWS = 25;
	localparam directed_row_t DIRECTED [0:NUM_ROWS-1] = '{
		'{4'd0, 18'sd0, 1'b1, 18'sd65536, 1'b0},
		'{4'd0, -18'sd65536, 1'b1, 18'sd65536, 1'b0},
		'{4'd1, 18'sd12345, 1'b1, 18'sd12345, 1'b0},
		'{4'd1, -18'sd65536, 1'b1, -18'sd65536, 1'b0},
		'{4'd2, 18'sd0, 1'b1, -18'sd32768, 1'b0},
		'{4'd2, 18'sd65536, 1'b1, 18'sd65536, 1'b0},
		'{4'd3, -18'sd65536, 1'b1, -18'sd65536, 1'b0},
		'{4'd4, 18'sd0, 1'b1, 18'sd24576, 1'b0},
		'{4'd5, 18'sd0, 1'b1, 18'sd0, 1'b0},
		'{4'd6, 18'sd65536, 1'b1, 18'sd65536, 1'b0},
		'{4'd7, -18'sd65536, 1'b1, -18'sd65536, 1'b0},
		'{4'd8, -18'sd65536, 1'b1, 18'sd65536, 1'b0},
		'{4'd9, 18'sd65536, 1'b1, 18'sd65536, 1'b0},
		'{4'd10, 18'sd32768, 1'b0, 18'sd0, 1'b0},
		'{4'd11, -18'sd40000, 1'b0, 18'sd0, 1'b0},
		'{4'd12, -18'sd65536, 1'b1, 18'sd65536, 1'b0},
		'{4'd12, 18'sd65536, 1'b1, 18'sd65536, 1'b0},
		'{4'd12, 18'sd1, 1'b0, 18'sd0, 1'b0},
		'{4'd13, 18'sd0, 1'b1, 18'sd0, 1'b1},
		'{4'd14, 18'sd65536, 1'b1, 18'sd0, 1'b1},
		'{4'd15, -18'sd131072, 1'b1, 18'sd0, 1'b1},
		'{4'd3, 18'sd131071, 1'b1, 18'sd65536, 1'b0},
		'{4'd4, -18'sd131072, 1'b1, 18'sd65536, 1'b0},
		'{4'd9, 18'sd70000, 1'b1, 18'sd65536, 1'b0},
		'{4'd7, 18'sd20000, 1'b0, 18'sd0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [3:0] order;
	logic signed [XW-1:0] arg_x;
	logic out_valid;
	logic out_ready;
	logic signed [XW-1:0] poly_value;
	logic bad_order;

	legendre_out_t pending_values [$];
	int mismatches = 0;
	bit calm = 0;

	legendre_polynomial_eval_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.order(order),
		.arg_x(arg_x),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.poly_value(poly_value),
		.bad_order(bad_order)
	);

	function automatic longint scaled_product(longint a, longint b);
		longint mag;
		bit neg;
		neg = (a < 0) != (b < 0);
		mag = (a < 0 ? -a : a) * (b < 0 ? -b : b);
		mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		return neg ? -mag : mag;
	endfunction

	function automatic legendre_out_t legendre_value(logic [3:0] n, logic signed [XW-1:0] x_in);
		legendre_out_t r;
		longint x;
		longint y;
		longint acc;
		longint mag;
		int s;
		bit neg;
		r = '0;
		if (int'(n) > TOP_ORDER) begin
			r.bad = 1'b1;
			return r;
		end
		x = x_in;
		if (x > UNITY) x = UNITY;
		if (x < -UNITY) x = -UNITY;
		y = scaled_product(x, x);
		acc = LEG_COEF[n][0] * UNITY;
		for (int k = 1; k <= int'(n) / 2; k++) begin
			acc = scaled_product(acc, y) + LEG_COEF[n][k] * UNITY;
		end
		if (n[0]) acc = scaled_product(acc, x);
		s = LEG_SHIFT[n];
		neg = acc < 0;
		mag = neg ? -acc : acc;
		if (s > 0) mag = (mag + (longint'(1) << (s - 1))) >>> s;
		if (mag > UNITY) mag = UNITY;
		r.value = XW'(neg ? -mag : mag);
		return r;
	endfunction

	function automatic logic signed [XW-1:0] random_arg();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 131072)) - 65536;
			6: v = int'($urandom_range(0, 262143)) - 131072;
			7: v = ($urandom_range(0, 1) ? 1 : -1) * (65536 - int'($urandom_range(0, 16)));
			8: v = int'($urandom_range(0, 512)) - 256;
			default: v = ($urandom_range(0, 2) - 1) * 65536;
		endcase
		return XW'(v);
	endfunction

	task automatic send_item(logic [3:0] n, logic signed [XW-1:0] x, bit typed,
			legendre_out_t known);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		order <= n;
		arg_x <= x;
		do @(posedge clk); while (!in_ready);
		pending_values.push_back(typed ? known : legendre_value(n, x));
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		order = '0;
		arg_x = '0;
		out_ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin
		legendre_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_values.size() == 0) begin
				$error("unexpected result transfer: poly_value %0d bad_order %0b",
					poly_value, bad_order);
				mismatches++;
			end else begin
				want = pending_values.pop_front();
				if (poly_value !== want.value) begin
					$error("poly_value: expected %0d, actual %0d", want.value, poly_value);
					mismatches++;
				end
				if (bad_order !== want.bad) begin
					$error("bad_order: expected %0b, actual %0b", want.bad, bad_order);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("** legendre_polynomial_eval_core: FAILED **");
		$finish;
	end

	initial begin
		legendre_out_t known;
		@(posedge arst_n);
		foreach (DIRECTED[i]) begin
			known.value = DIRECTED[i].value;
			known.bad = DIRECTED[i].bad;
			send_item(DIRECTED[i].ord, DIRECTED[i].x, DIRECTED[i].typed, known);
		end
		known = '0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1;
			send_item(($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
					: 4'($urandom_range(0, TOP_ORDER)), random_arg(), 1'b0, known);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_values.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("** legendre_polynomial_eval_core: PASSED **");
		end else begin
			$display("** legendre_polynomial_eval_core: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/lpe_pkg.sv
src/legendre_polynomial_eval_core.sv
src/lpe_checker.sv
dv/tb_legendre_polynomial_eval_core.sv
